// File: hw/rtl/bfa_pkg.sv
// shared types and constants of the bitmap frame allocator
`timescale 1ns / 1ps
package bfa_pkg;
	localparam int ACT_W    = 3;
	localparam int FRAME_W  = 18;
	localparam int COUNT_W  = 19;
	localparam int STATUS_W = 2;
	localparam int TOTAL_W  = 19;
	localparam int IN_W     = 40;
	localparam int OUT_W    = 64;

	typedef enum logic [ACT_W-1:0] {
		ACT_ALLOC_ONE   = 3'd0,
		ACT_FREE_ONE    = 3'd1,
		ACT_ALLOC_RUN   = 3'd2,
		ACT_FREE_RUN    = 3'd3,
		ACT_RESERVE_RUN = 3'd4
	} act_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_NONE  = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_ZERO  = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_A1_RD,
		ST_A1_CHK,
		ST_RS_RD,
		ST_RS_CHK,
		ST_MK_RD,
		ST_MK_WR,
		ST_DONE
	} state_t;
endpackage

// File: hw/rtl/bfa_map_mem.sv
// used-bit map memory, one write port and one registered read port
`timescale 1ns / 1ps
module bfa_map_mem #(
	parameter int DEPTH = 8192,
	parameter int AW    = 13,
	parameter int W     = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: hw/rtl/bfa_word_ops.sv
// bit range mask, lowest free bit and popcounts of one map word
`timescale 1ns / 1ps
module bfa_word_ops #(
	parameter int W  = 32,
	parameter int BW = 5,
	parameter int OW = 6
) (
	input  logic [W-1:0]  word,
	input  logic [BW-1:0] lo,
	input  logic [OW-1:0] hi,
	output logic [W-1:0]  mask,
	output logic [BW-1:0] first_zero,
	output logic [OW-1:0] pop_used,
	output logic [OW-1:0] pop_free
);
	always_comb begin
		mask       = '0;
		first_zero = '0;
		pop_used   = '0;
		pop_free   = '0;
		for (int i = 0; i < W; i++) begin
			mask[i] = (OW'(i) >= OW'(lo)) && (OW'(i) < hi);
		end
		for (int i = W - 1; i >= 0; i--) begin
			if (!word[i]) begin
				first_zero = BW'(i);
			end
		end
		for (int i = 0; i < W; i++) begin
			pop_used = pop_used + OW'(word[i] & mask[i]);
			pop_free = pop_free + OW'(~word[i] & mask[i]);
		end
	end
endmodule

// File: hw/rtl/bitmap_frame_allocator.sv
// bitmap page frame allocator top level
// Usage: one request per s_* transaction (action, frame, count); exactly one
// result per request on m_* (result_frame, status, free_frames, used_frames).
// The user must write total_frames on cfg_* only while idle; the block does not enforce it.
// After reset the map is filled with ones (all frames used), one word per
// cycle over all MAP_WORDS words (8192 by default); s_tready stays
// low until that pass ends. free_frames resets to zero.
// WORD_BITS must be a power of two (not checked); the start word of a frame comes from a shift.
// Steps, one request at a time, set by the registered map memory read port:
//   alloc one: A1_RD then A1_CHK for each map word scanned up to the first
//     word with a free bit, then DONE.
//   free one, free run, reserve run: MK_RD then MK_WR per map word touched, then DONE.
//   alloc run: RS_RD then one RS_CHK for a word that is all free or all used,
//     or one RS_CHK per bit of a mixed word; then MK_RD and MK_WR per word marked.
//   rejected requests: straight to DONE.
// The result sits in an output register; when m_tready is low the block holds it
// and waits in DONE with the next result until that register is free.
`timescale 1ns / 1ps
module bitmap_frame_allocator #(
	parameter int MAX_FRAMES = 262144,
	parameter int WORD_BITS  = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [bfa_pkg::IN_W-1:0]    s_tdata,  // action, frame, count
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [bfa_pkg::OUT_W-1:0]   m_tdata,  // result_frame, status, free_frames, used_frames
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bfa_pkg::TOTAL_W-1:0] cfg_data  // total_frames
);
	import bfa_pkg::*;

	localparam int MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BW = $clog2(WORD_BITS);
	localparam int OW = BW + 1;
	localparam int PW = ($clog2(MAX_FRAMES) + 2 > 21) ? $clog2(MAX_FRAMES) + 2 : 21;
	localparam logic [PW-1:0] MAXF = PW'(MAX_FRAMES);
	localparam logic [PW-1:0] WB = PW'(WORD_BITS);
	localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

	state_t state_q, state_d;

	logic [TOTAL_W-1:0]   total_q;
	logic [COUNT_W-1:0]   free_q;
	logic [AW-1:0]        word_q;
	logic [PW-1:0]        base_q;
	logic [BW-1:0]        off_q;
	logic [PW-1:0]        end_q;
	logic [PW-1:0]        limit_q;
	logic [PW-1:0]        count_q;
	logic [PW-1:0]        run_q;
	logic [PW-1:0]        start_q;
	logic [AW-1:0]        start_word_q;
	logic [PW-1:0]        start_base_q;
	logic [BW-1:0]        start_off_q;
	logic                 mk_set_q;
	logic [FRAME_W-1:0]   res_q;
	status_t              status_q;
	logic                 m_tvalid_q;
	logic [OUT_W-1:0]     m_tdata_q;

	act_t               in_act;
	logic [FRAME_W-1:0] in_frame;
	logic [COUNT_W-1:0] in_count;
	logic               accept;
	logic [PW-1:0]      in_end;
	logic               in_alloc;
	logic [AW-1:0]      in_word;
	logic [BW-1:0]      in_off;
	logic [PW-1:0]      in_base;
	status_t            in_status;

	logic           mem_we;

	logic [WORD_BITS-1:0] mem_wdata;
	logic [WORD_BITS-1:0] rd_word;
	logic [WORD_BITS-1:0] wo_mask;
	logic [BW-1:0]        wo_first_zero;
	logic [OW-1:0]        wo_pop_used;
	logic [OW-1:0]        wo_pop_free;
	logic [OW-1:0]        mk_hi;
	logic [PW-1:0]        mk_diff;

	logic           all_ones, all_zero, word_in_lim, fast, bit_free;
	logic [PW-1:0]  cur_f, run_new;
	logic           rs_found, rs_fail, rs_word_end, mk_last, a1_last, out_free;

	assign in_act   = act_t'(s_tdata[2:0]);
	assign in_frame = s_tdata[20:3];
	assign in_count = s_tdata[39:21];
	assign accept   = s_tvalid && s_tready;
	assign in_end   = (PW'(in_frame) + PW'(in_count) < MAXF) ?
		PW'(in_frame) + PW'(in_count) : MAXF;

	// start position of a request, word zero for the searches
	assign in_alloc = (in_act == ACT_ALLOC_ONE) || (in_act == ACT_ALLOC_RUN);
	assign in_off   = in_alloc ? '0 : in_frame[BW-1:0];
	assign in_word  = in_alloc ? '0 : AW'(PW'(in_frame) >> BW);
	assign in_base  = in_alloc ? '0 : PW'(in_frame) - PW'(in_off);

	always_comb begin
		in_status = STAT_OK;
		case (in_act)
			ACT_FREE_ONE: begin
				if (PW'(in_frame) >= MAXF) in_status = STAT_RANGE;
			end
			ACT_ALLOC_RUN, ACT_FREE_RUN, ACT_RESERVE_RUN: begin
				if (in_count == '0) in_status = STAT_ZERO;
			end
			default: ;
		endcase
	end

	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign out_free  = !m_tvalid_q || m_tready;

	bfa_map_mem #(.DEPTH(MAP_WORDS), .AW(AW), .W(WORD_BITS)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (word_q),
		.wdata (mem_wdata),
		.raddr (word_q),
		.rdata (rd_word)
	);

	bfa_word_ops #(.W(WORD_BITS), .BW(BW), .OW(OW)) u_ops (
		.word       (rd_word),
		.lo         (off_q),
		.hi         (mk_hi),
		.mask       (wo_mask),
		.first_zero (wo_first_zero),
		.pop_used   (wo_pop_used),
		.pop_free   (wo_pop_free)
	);

	assign all_ones    = (rd_word == '1);
	assign all_zero    = (rd_word == '0);
	assign word_in_lim = (base_q + WB <= limit_q);
	assign fast        = (off_q == '0) && word_in_lim && (all_ones || all_zero);
	assign cur_f       = base_q + PW'(off_q);
	assign bit_free    = !rd_word[off_q];
	assign run_new     = run_q + (fast ? WB : PW'(1));
	assign rs_found    = (fast ? all_zero : bit_free) && (run_new >= count_q);
	assign rs_fail     = !fast && (cur_f >= limit_q);
	assign rs_word_end = fast || (off_q == BW'(WORD_BITS - 1));
	assign mk_diff     = end_q - base_q;
	assign mk_hi       = (mk_diff >= WB) ? OW'(WORD_BITS) : OW'(mk_diff);
	assign mk_last     = (base_q + WB >= end_q);
	assign a1_last     = (word_q == LAST_WORD);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (word_q == LAST_WORD) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (in_act)
						ACT_ALLOC_ONE: state_d = ST_A1_RD;
						ACT_FREE_ONE: begin
							state_d = (PW'(in_frame) >= MAXF) ? ST_DONE : ST_MK_RD;
						end
						ACT_ALLOC_RUN, ACT_FREE_RUN, ACT_RESERVE_RUN: begin
							if (in_count == '0) state_d = ST_DONE;
							else if (in_act == ACT_ALLOC_RUN) state_d = ST_RS_RD;
							else if (PW'(in_frame) >= in_end) state_d = ST_DONE;
							else state_d = ST_MK_RD;
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_A1_RD:  state_d = ST_A1_CHK;
			ST_A1_CHK: begin
				if (!all_ones || a1_last) state_d = ST_DONE;
				else state_d = ST_A1_RD;
			end
			ST_RS_RD:  state_d = ST_RS_CHK;
			ST_RS_CHK: begin
				if (rs_fail) state_d = ST_DONE;
				else if (rs_found) state_d = ST_MK_RD;
				else if (rs_word_end) state_d = ST_RS_RD;
			end
			ST_MK_RD:  state_d = ST_MK_WR;
			ST_MK_WR:  state_d = mk_last ? ST_DONE : ST_MK_RD;
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready  = 1'b0;
		mem_we    = 1'b0;
		mem_wdata = '1;
		unique case (state_q)
			ST_CLEAR: mem_we = 1'b1;
			ST_IDLE:  s_tready = 1'b1;
			ST_A1_CHK: begin
				mem_we    = !all_ones;
				mem_wdata = rd_word | (WORD_BITS'(1) << wo_first_zero);
			end
			ST_MK_WR: begin
				mem_we    = 1'b1;
				mem_wdata = mk_set_q ? (rd_word | wo_mask) : (rd_word & ~wo_mask);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			word_q     <= '0;
			total_q    <= '0;
			free_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) total_q <= cfg_data;
			if (state_q == ST_DONE && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					word_q <= (word_q == LAST_WORD) ? '0 : word_q + AW'(1);
				end
				ST_IDLE: begin
					if (accept) begin
						res_q     <= '0;
						status_q  <= in_status;
						word_q    <= in_word;
						base_q    <= in_base;
						off_q     <= in_off;
						run_q     <= '0;
						count_q   <= PW'(in_count);
						limit_q   <= (PW'(total_q) < MAXF) ? PW'(total_q) : MAXF;
						mk_set_q  <= (in_act == ACT_RESERVE_RUN);
						end_q     <= (in_act == ACT_FREE_ONE) ? PW'(in_frame) + PW'(1)
							: in_end;
					end
				end
				ST_A1_CHK: begin
					if (!all_ones) begin
						res_q  <= FRAME_W'(base_q + PW'(wo_first_zero));
						free_q <= free_q - COUNT_W'(1);
					end else if (a1_last) begin
						status_q <= STAT_NONE;
					end else begin
						word_q <= word_q + AW'(1);
						base_q <= base_q + WB;
					end
				end
				ST_RS_CHK: begin
					if (rs_fail) begin
						status_q <= STAT_NONE;
					end else if (rs_found) begin
						if (run_q == '0) begin
							res_q  <= FRAME_W'(cur_f);
							word_q <= word_q;
							base_q <= base_q;
							off_q  <= off_q;
							end_q  <= cur_f + count_q;
						end else begin
							res_q  <= FRAME_W'(start_q);
							word_q <= start_word_q;
							base_q <= start_base_q;
							off_q  <= start_off_q;
							end_q  <= start_q + count_q;
						end
						mk_set_q <= 1'b1;
					end else begin
						if (fast ? all_zero : bit_free) begin
							run_q <= run_new;
							if (run_q == '0) begin
								start_q      <= cur_f;
								start_word_q <= word_q;
								start_base_q <= base_q;
								start_off_q  <= off_q;
							end
						end else begin
							run_q <= '0;
						end
						if (rs_word_end) begin
							word_q <= word_q + AW'(1);
							base_q <= base_q + WB;
							off_q  <= '0;
						end else begin
							off_q <= off_q + BW'(1);
						end
					end
				end
				ST_MK_WR: begin
					if (mk_set_q) free_q <= free_q - COUNT_W'(wo_pop_free);
					else free_q <= free_q + COUNT_W'(wo_pop_used);
					word_q <= word_q + AW'(1);
					base_q <= base_q + WB;
					off_q  <= '0;
				end
				ST_DONE: begin
					if (out_free) begin
						m_tdata_q  <= {6'b0,
							(total_q > free_q) ? total_q - free_q : TOTAL_W'(0),
							free_q, status_q, res_q};
					end
				end
				default: ;
			endcase
		end
	end
endmodule

// File: tb/bfa_checker.sv
// checker for the bitmap frame allocator: predicts each result and compares it
`timescale 1ns / 1ps
module bfa_checker (
	input  logic                         clk,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [bfa_pkg::IN_W-1:0]     s_tdata,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [bfa_pkg::OUT_W-1:0]    m_tdata,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [bfa_pkg::TOTAL_W-1:0]  cfg_data,
	output int                           errors,
	output int                           pending
);
	import bfa_pkg::*;

	localparam int NFRAMES = 262144;
	localparam int NWORDS  = NFRAMES / 32;

	typedef struct packed {
		logic [18:0]         used_frames;
		logic [18:0]         free_frames;
		status_t             status;
		logic [FRAME_W-1:0]  result_frame;
	} alloc_result_t;

	logic [31:0]   frame_map [NWORDS];
	int unsigned   free_cnt;
	int unsigned   total_frames;
	alloc_result_t expected_q[$];

	initial begin
		for (int w = 0; w < NWORDS; w++)
			frame_map[w] = '1;
		free_cnt = 0;
		total_frames = 0;
		errors = 0;
		pending = 0;
	end

	function automatic logic is_used(int unsigned f);
		return frame_map[f / 32][f % 32];
	endfunction

	function automatic alloc_result_t predict_alloc(logic [IN_W-1:0] d);
		logic [2:0]   act;
		int unsigned  fr, cnt, lim, start, run, f;
		bit           found;
		alloc_result_t r;
		act = d[2:0];
		fr = 32'(d[20:3]);
		cnt = 32'(d[39:21]);
		r = '0;
		r.status = STAT_OK;
		found = 0;
		if (act == ACT_ALLOC_ONE) begin
			for (int w = 0; w < NWORDS && !found; w++) begin
				if (frame_map[w] != '1) begin
					for (int i = 0; i < 32; i++) begin
						if (!frame_map[w][i]) begin
							found = 1;
							r.result_frame = FRAME_W'(w * 32 + i);
							frame_map[w][i] = 1'b1;
							free_cnt--;
							break;
						end
					end
				end
			end
			if (!found)
				r.status = STAT_NONE;
		end else if (act == ACT_FREE_ONE) begin
			if (fr >= NFRAMES)
				r.status = STAT_RANGE;
			else if (is_used(fr)) begin
				frame_map[fr / 32][fr % 32] = 1'b0;
				free_cnt++;
			end
		end else if ((act == ACT_ALLOC_RUN || act == ACT_FREE_RUN ||
				act == ACT_RESERVE_RUN) && cnt == 0) begin
			r.status = STAT_ZERO;
		end else if (act == ACT_ALLOC_RUN) begin
			lim = total_frames < NFRAMES ? total_frames : NFRAMES;
			start = 0;
			run = 0;
			for (f = 0; f < lim; f++) begin
				if (!is_used(f)) begin
					if (run == 0)
						start = f;
					run++;
					if (run >= cnt) begin
						found = 1;
						break;
					end
				end else
					run = 0;
			end
			if (found) begin
				for (int unsigned i = 0; i < cnt; i++)
					frame_map[(start + i) / 32][(start + i) % 32] = 1'b1;
				free_cnt -= cnt;
				r.result_frame = FRAME_W'(start);
			end else
				r.status = STAT_NONE;
		end else if (act == ACT_FREE_RUN || act == ACT_RESERVE_RUN) begin
			for (int unsigned i = 0; i < cnt; i++) begin
				f = fr + i;
				if (f >= NFRAMES)
					break;
				if (act == ACT_FREE_RUN && is_used(f)) begin
					frame_map[f / 32][f % 32] = 1'b0;
					free_cnt++;
				end else if (act == ACT_RESERVE_RUN && !is_used(f)) begin
					frame_map[f / 32][f % 32] = 1'b1;
					free_cnt--;
				end
			end
		end
		r.free_frames = free_cnt[18:0];
		r.used_frames = 19'(total_frames > 32'(r.free_frames) ?
			total_frames - 32'(r.free_frames) : 0);
		return r;
	endfunction

	always @(posedge clk) begin
		alloc_result_t got, exp_r;
		if (cfg_valid && cfg_ready)
			total_frames = 32'(cfg_data);
		if (s_tvalid && s_tready)
			expected_q.push_back(predict_alloc(s_tdata));
		if (m_tvalid && m_tready) begin
			got = m_tdata[$bits(alloc_result_t)-1:0];
			if (expected_q.size() == 0) begin
				$error("result transaction with nothing expected");
				errors++;
			end else begin
				exp_r = expected_q.pop_front();
				if (got.result_frame !== exp_r.result_frame) begin
					$error("result_frame exp %0d got %0d", exp_r.result_frame,
						got.result_frame);
					errors++;
				end
				if (got.status !== exp_r.status) begin
					$error("status exp %0d got %0d", exp_r.status, got.status);
					errors++;
				end
				if (got.free_frames !== exp_r.free_frames) begin
					$error("free_frames exp %0d got %0d", exp_r.free_frames,
						got.free_frames);
					errors++;
				end
				if (got.used_frames !== exp_r.used_frames) begin
					$error("used_frames exp %0d got %0d", exp_r.used_frames,
						got.used_frames);
					errors++;
				end
			end
		end
		pending <= expected_q.size();
	end
endmodule

// File: tb/tb.sv
// testbench top for the bitmap frame allocator
`timescale 1ns / 1ps
module tb;
	import bfa_pkg::*;

	localparam int          TOP_FRAME    = 262143;
	localparam int          ALL_FRAMES   = 262144;
	localparam logic [2:0]  ACT_SPARE_LO = 3'd5;
	localparam logic [2:0]  ACT_SPARE_HI = 3'd7;
	localparam int          LIMIT        = 200000000;

	logic                clk = 0;
	logic                arst_n = 0;
	logic                s_tvalid = 0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata = '0;  // action, frame, count
	logic                m_tvalid;
	logic                m_tready = 0;
	logic [OUT_W-1:0]    m_tdata;       // result_frame, status, free_frames, used_frames
	logic                cfg_valid = 0;
	logic                cfg_ready;
	logic [TOTAL_W-1:0]  cfg_data = '0;
	int                  errors, pending;
	bit                  idle_on = 1;
	int                  cycles = 0;
	int unsigned         totals[8] = '{262144, 0, 3000, 1024, 0, 4096, 262143, 5000};

	always #5 clk = ~clk;

	bitmap_frame_allocator dut (.*);

	bfa_checker chk (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side back-pressure
	initial begin
		@(posedge clk iff arst_n);
		forever begin
			if (idle_on && $urandom_range(0, 3) == 0)
				m_tready <= 0;
			else
				m_tready <= 1;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	end

	task automatic send(logic [2:0] act, int unsigned fr, int unsigned cnt);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {cnt[18:0], fr[17:0], act};
		@(posedge clk iff s_tready);
	endtask

	task automatic write_total(int unsigned v);
		s_tvalid <= 0;
		@(posedge clk);
		while (pending != 0 || m_tvalid) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1;
		cfg_data <= v[18:0];
		@(posedge clk iff cfg_ready);
		cfg_valid <= 0;
	endtask

	task automatic send_random();
		int unsigned k, fr, cnt;
		logic [2:0] act;
		k = $urandom_range(0, 99);
		if (k < 25) act = ACT_ALLOC_ONE;
		else if (k < 45) act = ACT_FREE_ONE;
		else if (k < 67) act = ACT_ALLOC_RUN;
		else if (k < 83) act = ACT_FREE_RUN;
		else if (k < 96) act = ACT_RESERVE_RUN;
		else act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
		k = $urandom_range(0, 99);
		fr = k < 85 ? $urandom_range(0, 4095) : k < 95 ? $urandom_range(0, TOP_FRAME) :
			$urandom_range(TOP_FRAME - 4095, TOP_FRAME);
		k = $urandom_range(0, 99);
		if (k < 80) cnt = $urandom_range(1, 64);
		else if (k < 92) cnt = $urandom_range(1, 1024);
		else if (k < 96) cnt = 0;
		else begin
			// big runs kept near the top so few words are touched
			cnt = $urandom_range(0, ALL_FRAMES);
			fr = $urandom_range(TOP_FRAME - 4095, TOP_FRAME);
		end
		if (act == ACT_ALLOC_RUN && totals_big() && cnt > 64)
			cnt = $urandom_range(1, 64);
		send(act, fr, cnt);
	endtask

	function automatic bit totals_big();
		return chk.total_frames > 8192;
	endfunction

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		write_total(ALL_FRAMES);
		send(ACT_ALLOC_ONE, 0, 1);
		send(ACT_ALLOC_RUN, 0, 1);
		send(ACT_FREE_ONE, 0, 0);
		send(ACT_FREE_ONE, 0, 0);
		send(ACT_FREE_ONE, TOP_FRAME, 0);
		send(ACT_FREE_RUN, 0, ALL_FRAMES);
		send(ACT_ALLOC_RUN, 0, ALL_FRAMES);
		send(ACT_FREE_RUN, TOP_FRAME - 3, 100);
		send(ACT_RESERVE_RUN, 0, ALL_FRAMES);
		send(ACT_ALLOC_RUN, 0, 0);
		send(ACT_FREE_RUN, 7, 0);
		send(ACT_RESERVE_RUN, 7, 0);
		send(ACT_FREE_RUN, 5, 10);
		send(ACT_ALLOC_RUN, 0, 11);
		send(ACT_ALLOC_ONE, 0, 0);
		send(ACT_ALLOC_RUN, 0, 9);
		send(ACT_FREE_RUN, 40, 30);
		send(ACT_RESERVE_RUN, 50, 1);
		send(ACT_ALLOC_ONE, 0, 0);
		send(ACT_SPARE_HI, TOP_FRAME, ALL_FRAMES);
		send(ACT_SPARE_LO, 0, 0);
		send(ACT_FREE_ONE, 131072, 0);
		for (int p = 0; p < 8; p++) begin
			if (p == 3)
				totals[p] = $urandom_range(0, ALL_FRAMES);
			write_total(totals[p]);
			if (p == 7)
				idle_on = 0;
			for (int i = 0; i < 225; i++)
				send_random();
		end
		s_tvalid <= 0;
		while (pending != 0 || m_tvalid) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
